@@ sv/cqoe_pkg.sv @@
// Package: shared widths, codes, item struct and index helpers for the odd/even queue.
`default_nettype none

package cqoe_pkg;

  // Storage geometry
  localparam int Depth = 16;
  localparam int DataW = 32;
  localparam int IdxW  = $clog2(Depth);
  localparam int CapW  = $clog2(Depth + 1);

  // Port field widths
  localparam int CmdW  = 2;
  localparam int WordW = 32;
  localparam int StatW = 2;
  localparam int CfgW  = 5;

  // Command queue between front and back
  localparam int FqDepth = 2;
  localparam int FqPtrW  = $clog2(FqDepth);
  localparam int FqCntW  = $clog2(FqDepth + 1);

  typedef enum logic [CmdW-1:0] {
    OP_INSERT  = 2'd0,
    OP_DELETE  = 2'd1,
    OP_DISPLAY = 2'd2,
    OP_DUMP    = 2'd3
  } op_e;

  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } stat_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FWD,
    BK_BWD,
    BK_DRAIN
  } bk_state_e;

  typedef struct packed {
    op_e              op;
    logic [DataW-1:0] value;
  } item_t;

  typedef struct packed {
    logic            idle;
    logic            empty;
    logic [CapW-1:0] cap;
  } bk_stat_t;

  // next slot, wrapping at the active capacity
  function automatic logic [IdxW-1:0] idx_inc(input logic [IdxW-1:0] idx,
                                              input logic [CapW-1:0] cap);
    logic [CapW-1:0] s;
    s = CapW'(idx) + CapW'(1);
    return (s == cap) ? '0 : IdxW'(s);
  endfunction

  // previous slot, wrapping at the active capacity
  function automatic logic [IdxW-1:0] idx_dec(input logic [IdxW-1:0] idx,
                                              input logic [CapW-1:0] cap);
    return (idx == '0) ? IdxW'(cap - CapW'(1)) : idx - IdxW'(1);
  endfunction

  // clamp a written capacity to 1..Depth
  function automatic logic [CapW-1:0] cap_sat(input logic [CfgW-1:0] w);
    logic [CapW-1:0] r;
    if (w == '0) begin
      r = CapW'(1);
    end else if (32'(w) > 32'(Depth)) begin
      r = CapW'(Depth);
    end else begin
      r = CapW'(w);
    end
    return r;
  endfunction

  // sign-extend a stored word to the port width
  function automatic logic [WordW-1:0] widen(input logic [DataW-1:0] d);
    return WordW'($signed(d));
  endfunction

endpackage

`default_nettype wire

@@ sv/cqoe_cmd_if.sv @@
// Interface: command channel (valid/ready with command and value).
`default_nettype none

interface cqoe_cmd_if;
  logic                               valid;
  logic                               ready;
  logic [cqoe_pkg::CmdW-1:0]          command;
  logic signed [cqoe_pkg::WordW-1:0]  value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

`default_nettype wire

@@ sv/cqoe_res_if.sv @@
// Interface: result channel (valid/ready with status, data and last).
`default_nettype none

interface cqoe_res_if;
  logic                               valid;
  logic                               ready;
  logic [cqoe_pkg::StatW-1:0]         status;
  logic signed [cqoe_pkg::WordW-1:0]  data;
  logic                               last;

  modport source (output valid, output status, output data, output last, input ready);
  modport sink   (input valid, input status, input data, input last, output ready);
endinterface

`default_nettype wire

@@ sv/cqoe_front.sv @@
// Front end: accepts command items, classifies them and queues them for the back end.
`default_nettype none

module cqoe_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  cqoe_cmd_if.sink            cmd_i,
  output logic                q_valid_o,
  output cqoe_pkg::item_t     q_item_o,
  input  wire                 q_pop_i
);

  cqoe_pkg::item_t                  fq_mem [cqoe_pkg::FqDepth];
  logic [cqoe_pkg::FqPtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [cqoe_pkg::FqPtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [cqoe_pkg::FqCntW-1:0]      cnt_q, cnt_d;
  logic                             push;
  logic                             pop;
  cqoe_pkg::item_t                  in_item;

  // classify the raw command
  always_comb begin
    in_item.value = cqoe_pkg::DataW'(cmd_i.value);
    in_item.op    = cqoe_pkg::op_e'(cmd_i.command);
  end

  assign cmd_i.ready = (cnt_q != cqoe_pkg::FqCntW'(cqoe_pkg::FqDepth));
  assign push        = cmd_i.valid && cmd_i.ready;
  assign pop         = q_pop_i && (cnt_q != '0);

  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = fq_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == cqoe_pkg::FqPtrW'(cqoe_pkg::FqDepth - 1)) ? '0
                 : wr_ptr_q + cqoe_pkg::FqPtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == cqoe_pkg::FqPtrW'(cqoe_pkg::FqDepth - 1)) ? '0
                 : rd_ptr_q + cqoe_pkg::FqPtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + cqoe_pkg::FqCntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - cqoe_pkg::FqCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fq_mem[wr_ptr_q] <= in_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/cqoe_back.sv @@
// Back end: queue state, slot memory, display/dump walker and result register.
`default_nettype none

module cqoe_back (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [cqoe_pkg::CfgW-1:0]     cfg_wdata_i,
  input  wire                          q_valid_i,
  input  wire cqoe_pkg::item_t         q_item_i,
  output logic                         q_pop_o,
  cqoe_res_if.source                   res_o,
  output cqoe_pkg::bk_stat_t           stat_o
);

  cqoe_pkg::bk_state_e              state_q, state_d;
  logic [cqoe_pkg::IdxW-1:0]        head_q, tail_q, ptr_q;
  logic                             empty_q;
  logic [cqoe_pkg::CapW-1:0]        cap_q;
  logic                             dump_q;

  logic [cqoe_pkg::DataW-1:0]       mem [cqoe_pkg::Depth];
  logic [cqoe_pkg::DataW-1:0]       rdata_q;
  logic                             rv_q, rfin_q, rbwd_q;

  logic                             pv_q, pfin_q;
  logic [cqoe_pkg::DataW-1:0]       pdata_q;

  logic                             ov_q;
  cqoe_pkg::stat_e                  ostat_q;
  logic [cqoe_pkg::WordW-1:0]       odata_q;
  logic                             olast_q;

  logic                             issuing, idle;
  logic                             out_free, keep, need, cons;
  logic                             rd_en, pass_end, iss_fin;
  logic                             pf_out, pend_out, pend_take;
  logic                             start_walk, direct;
  logic                             full;
  logic [cqoe_pkg::IdxW-1:0]        tail_nxt;
  cqoe_pkg::stat_e                  dstat;

  // ---- next state ----
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cqoe_pkg::BK_IDLE: begin
        if (q_pop_o && start_walk) begin
          state_d = cqoe_pkg::BK_FWD;
        end
      end
      cqoe_pkg::BK_FWD: begin
        if (rd_en && pass_end) begin
          state_d = dump_q ? cqoe_pkg::BK_BWD : cqoe_pkg::BK_DRAIN;
        end
      end
      cqoe_pkg::BK_BWD: begin
        if (rd_en && pass_end) begin
          state_d = cqoe_pkg::BK_DRAIN;
        end
      end
      cqoe_pkg::BK_DRAIN: begin
        if (!rv_q && !pv_q) begin
          state_d = cqoe_pkg::BK_IDLE;
        end
      end
    endcase
  end

  // ---- state decode ----
  always_comb begin
    issuing = 1'b0;
    idle    = 1'b0;
    unique case (state_q)
      cqoe_pkg::BK_IDLE:  idle    = 1'b1;
      cqoe_pkg::BK_FWD:   issuing = 1'b1;
      cqoe_pkg::BK_BWD:   issuing = 1'b1;
      cqoe_pkg::BK_DRAIN: issuing = 1'b0;
    endcase
  end

  assign out_free = !ov_q || res_o.ready;

  // walker: forward pass ends at tail, backward pass at head
  assign pass_end = (state_q == cqoe_pkg::BK_FWD) ? (ptr_q == tail_q) : (ptr_q == head_q);
  assign iss_fin  = pass_end && ((state_q == cqoe_pkg::BK_BWD) || !dump_q);

  // consumer: one entry back from memory, keep or skip it
  assign keep = !dump_q || (rbwd_q ? !rdata_q[0] : rdata_q[0]);
  always_comb begin
    if (keep) begin
      need = pv_q ? out_free : 1'b1;
    end else begin
      need = rfin_q ? out_free : 1'b1;
    end
  end
  assign cons      = rv_q && need;
  assign rd_en     = issuing && (!rv_q || cons);
  assign pf_out    = pv_q && pfin_q && out_free;
  // pending entry leaves with last set when nothing more is kept
  assign pend_out  = pf_out || (cons && keep && pv_q) || (cons && !keep && rfin_q);
  assign pend_take = cons && keep;

  // command handling in idle
  assign tail_nxt   = cqoe_pkg::idx_inc(tail_q, cap_q);
  assign full       = !empty_q && (tail_nxt == head_q);
  assign start_walk = ((q_item_i.op == cqoe_pkg::OP_DISPLAY) ||
                       (q_item_i.op == cqoe_pkg::OP_DUMP)) && !empty_q;
  assign q_pop_o    = idle && q_valid_i && (start_walk || out_free);
  assign direct     = q_pop_o && !start_walk;

  always_comb begin
    unique case (q_item_i.op)
      cqoe_pkg::OP_INSERT:  dstat = full ? cqoe_pkg::ST_FULL : cqoe_pkg::ST_OK;
      cqoe_pkg::OP_DELETE:  dstat = empty_q ? cqoe_pkg::ST_EMPTY : cqoe_pkg::ST_OK;
      cqoe_pkg::OP_DISPLAY: dstat = cqoe_pkg::ST_EMPTY;
      cqoe_pkg::OP_DUMP:    dstat = cqoe_pkg::ST_EMPTY;
    endcase
  end

  // ---- slot memory ----
  always_ff @(posedge clk_i) begin
    if (direct && (q_item_i.op == cqoe_pkg::OP_INSERT) && !full) begin
      mem[empty_q ? '0 : tail_nxt] <= q_item_i.value;
    end
    if (rd_en) begin
      rdata_q <= mem[ptr_q];
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rfin_q <= iss_fin;
      rbwd_q <= (state_q == cqoe_pkg::BK_BWD);
    end
    if (pend_take) begin
      pdata_q <= rdata_q;
      pfin_q  <= rfin_q;
    end
    if (direct) begin
      ostat_q <= dstat;
      odata_q <= '0;
      olast_q <= 1'b1;
    end else if (pend_out) begin
      ostat_q <= cqoe_pkg::ST_OK;
      odata_q <= cqoe_pkg::widen(pdata_q);
      olast_q <= !(cons && keep);
    end
    if (q_pop_o && start_walk) begin
      dump_q <= (q_item_i.op == cqoe_pkg::OP_DUMP);
    end
  end

  // ---- control registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cqoe_pkg::BK_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      ptr_q   <= '0;
      empty_q <= 1'b1;
      cap_q   <= cqoe_pkg::CapW'(cqoe_pkg::Depth);
      rv_q    <= 1'b0;
      pv_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        cap_q   <= cqoe_pkg::cap_sat(cfg_wdata_i);
        head_q  <= '0;
        tail_q  <= '0;
        empty_q <= 1'b1;
      end else if (direct && !empty_q && (q_item_i.op == cqoe_pkg::OP_DELETE)) begin
        if (head_q == tail_q) begin
          head_q  <= '0;
          tail_q  <= '0;
          empty_q <= 1'b1;
        end else begin
          head_q <= cqoe_pkg::idx_inc(head_q, cap_q);
        end
      end else if (direct && !full && (q_item_i.op == cqoe_pkg::OP_INSERT)) begin
        if (empty_q) begin
          head_q <= '0;
          tail_q <= '0;
        end else begin
          tail_q <= tail_nxt;
        end
        empty_q <= 1'b0;
      end

      // walk pointer
      if (q_pop_o && start_walk) begin
        ptr_q <= head_q;
      end else if (rd_en) begin
        if ((state_q == cqoe_pkg::BK_FWD) && pass_end) begin
          ptr_q <= tail_q;
        end else if (state_q == cqoe_pkg::BK_FWD) begin
          ptr_q <= cqoe_pkg::idx_inc(ptr_q, cap_q);
        end else begin
          ptr_q <= cqoe_pkg::idx_dec(ptr_q, cap_q);
        end
      end

      if (rd_en) begin
        rv_q <= 1'b1;
      end else if (cons) begin
        rv_q <= 1'b0;
      end

      if (pend_take) begin
        pv_q <= 1'b1;
      end else if (pend_out) begin
        pv_q <= 1'b0;
      end

      if (direct || pend_out) begin
        ov_q <= 1'b1;
      end else if (res_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign res_o.valid  = ov_q;
  assign res_o.status = ostat_q;
  assign res_o.data   = odata_q;
  assign res_o.last   = olast_q;

  assign stat_o.idle  = idle;
  assign stat_o.empty = empty_q;
  assign stat_o.cap   = cap_q;

endmodule

`default_nettype wire

@@ sv/circular_queue_odd_even_dump.sv @@
// Top level: circular queue with insert, delete, display and odd/even dump commands.
//
//   channel   dir  handshake        payload
//   cmd_i     in   valid/ready      command[1:0], value[31:0] signed
//   res_o     out  valid/ready      status[1:0], data[31:0] signed, last
//   cfg       in   cfg_we_i only    cfg_wdata_i[4:0] capacity (clamped to 1..16)
//
// Insert and delete give one result item; it passes through the front queue, then the result
// register. With res_o ready and no walk running, the back end takes one command per cycle.
// Display walks from head to tail; dump walks to tail and back to head. The walker reads one
// slot per cycle from the single read port of the slot memory, unless res_o stalls.
// A walked result waits in a pending register so its last flag is known before it goes out.
// rst_ni is asynchronous, active low: empty queue, capacity 16. Slot contents are not reset.
// A stalled res_o holds the walker; the two-entry command queue lets cmd_i take two more items.
`default_nettype none

module circular_queue_odd_even_dump (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [cqoe_pkg::CfgW-1:0]     cfg_wdata_i,
  cqoe_cmd_if.sink                     cmd_i,
  cqoe_res_if.source                   res_o
);

  logic                 q_valid;
  logic                 q_pop;
  cqoe_pkg::item_t      q_item;
  cqoe_pkg::bk_stat_t   bk_stat;

  // accepts and classifies items, buffers up to two
  cqoe_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd_i),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  // carries out one command at a time against the queue state
  cqoe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .res_o       (res_o),
    .stat_o      (bk_stat)
  );

`ifndef SYNTH
  // back end only takes a command the front holds
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("pop from empty command queue");

  // active capacity always within 1..Depth
  a_cap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bk_stat.cap != '0) && (bk_stat.cap <= cqoe_pkg::CapW'(cqoe_pkg::Depth)))
    else $error("capacity out of range");

  // a capacity write empties the queue
  a_cfg_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> bk_stat.empty) else $error("queue not empty after capacity write");

  // a result only appears after a command was taken or a walk is running
  a_res_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> ($past(q_pop) || !$past(bk_stat.idle)))
    else $error("result with no command behind it");
`endif

endmodule

`default_nettype wire
